// ----- src/brm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// brm_pkg
// Types and constants shared by the bucketed range map files.
// ============================================================================
package brm_pkg;

    localparam int BUCKETS_DEF = 16;
    localparam int ENTRIES_DEF = 64;

    typedef logic [15:0] value_t;
    typedef logic [31:0] key_t;
    typedef logic [2:0]  status_t;

    localparam status_t ST_HIT       = 3'd0;
    localparam status_t ST_DEFAULT   = 3'd1;
    localparam status_t ST_ADDED     = 3'd2;
    localparam status_t ST_REPLACED  = 3'd3;
    localparam status_t ST_OVERLAP   = 3'd4;
    localparam status_t ST_FULL      = 3'd5;
    localparam status_t ST_BAD_RANGE = 3'd6;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    typedef enum logic [1:0] {
        KIND_INSERT,
        KIND_SPLIT,
        KIND_TRIM_START,
        KIND_TRIM_END
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_READ,
        S_LK_CHECK,
        S_SC_READ,
        S_SC_CHECK,
        S_SH_READ,
        S_SH_WRITE,
        S_FIX_READ,
        S_FIX_WAIT,
        S_FIX_WRITE,
        S_PUT,
        S_DONE
    } state_t;

    typedef struct packed {
        key_t   start;
        key_t   stop;
        value_t value;
    } entry_t;

endpackage
`default_nettype wire

// ----- src/brm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// brm_if
// Valid/ready channel carrying a payload of a given type.
// ============================================================================
interface brm_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/brm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// brm_ram
// Single-port synchronous RAM with registered read data.
// ============================================================================
module brm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- src/brm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// brm_ctrl
// Sequencer: scans, shifts and writes one bucket of the entry memory.
// ============================================================================
module brm_ctrl #(
    parameter int BUCKETS = brm_pkg::BUCKETS_DEF,
    parameter int ENTRIES = brm_pkg::ENTRIES_DEF,
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int EW = $clog2(ENTRIES),
    localparam int FW = $clog2(ENTRIES + 1),
    localparam int AW = $clog2(BUCKETS * ENTRIES)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            in_cmd,
    input  wire logic [3:0]      in_bucket,
    input  wire brm_pkg::key_t   in_key,
    input  wire brm_pkg::key_t   in_end,
    input  wire brm_pkg::value_t in_value,
    input  wire brm_pkg::value_t fallback_value,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output brm_pkg::value_t      res_value,
    output brm_pkg::status_t     res_status,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_addr,
    output brm_pkg::entry_t      mem_wdata,
    input  wire brm_pkg::entry_t mem_rdata
);
    import brm_pkg::*;

    state_t          state_reg, state_next;
    logic [BW-1:0]   bkt_reg;
    key_t            s_reg, e_reg;
    value_t          v_reg, v_next;
    logic [FW-1:0]   i_reg, i_next;
    logic [FW-1:0]   idx_reg, idx_next;
    logic [FW-1:0]   fill_reg [BUCKETS];
    logic [FW-1:0]   fill;
    kind_t           kind_reg, kind_next;
    entry_t          fix_reg, fix_next;
    logic            res_valid_reg, res_valid_next;
    value_t          res_value_reg, res_value_next;
    status_t         res_status_reg, res_status_next;
    logic [1:0]      gap;
    logic            fill_we;
    logic [FW-1:0]   fill_wdata;
    logic [FW:0]     need_fill;
    logic [BW-1:0]   bkt_in;
    logic [BW-1:0]   wrap_lut [16];

    for (genvar k = 0; k < 16; k++)
    begin : g_wrap
        assign wrap_lut[k] = BW'(k % BUCKETS);
    end

    assign bkt_in = wrap_lut[in_bucket];

    assign fill = fill_reg[bkt_reg];
    assign gap  = (kind_reg == KIND_SPLIT) ? 2'd2 : 2'd1;
    assign need_fill = {1'b0, fill} + (FW+1)'(gap);

    function automatic logic [AW-1:0] addr_of(logic [BW-1:0] b, logic [FW-1:0] j);
        logic [AW+FW-1:0] a;
        begin
            a = (AW+FW)'(b) * (AW+FW)'(ENTRIES) + (AW+FW)'(j);
            addr_of = a[AW-1:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < BUCKETS; k++)
            begin
                fill_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (fill_we)
            begin
                fill_reg[bkt_reg] <= fill_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            bkt_reg <= bkt_in;
            s_reg   <= in_key;
            e_reg   <= in_end;
        end
        v_reg          <= (in_valid && in_ready) ? in_value : v_next;
        i_reg          <= i_next;
        idx_reg        <= idx_next;
        kind_reg       <= kind_next;
        fix_reg        <= fix_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        i_next          = i_reg;
        idx_next        = idx_reg;
        kind_next       = kind_reg;
        fix_next        = fix_reg;
        res_valid_next  = res_valid_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        in_ready        = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = addr_of(bkt_reg, i_reg);
        mem_wdata       = mem_rdata;
        fill_we         = 1'b0;
        fill_wdata      = need_fill[FW-1:0];
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !res_valid_reg || res_ready;
                if (in_valid && in_ready)
                begin
                    state_next = (in_cmd == CMD_ADD) ? S_SC_READ : S_LK_READ;
                    if (in_cmd == CMD_ADD)
                    begin
                        i_next = fill_reg[bkt_in];
                    end
                    else
                    begin
                        i_next = '0;
                    end
                    kind_next = KIND_INSERT;
                    idx_next  = '0;
                end
            end
            S_LK_READ:
            begin
                if (i_reg == fill)
                begin
                    res_value_next  = fallback_value;
                    res_status_next = ST_DEFAULT;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_LK_CHECK;
                end
            end
            S_LK_CHECK:
            begin
                if (s_reg >= mem_rdata.start && s_reg <= mem_rdata.stop)
                begin
                    res_value_next  = mem_rdata.value;
                    res_status_next = ST_HIT;
                    state_next      = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_LK_READ;
                end
            end
            S_SC_READ:
            begin
                res_value_next = '0;
                if (s_reg > e_reg)
                begin
                    res_status_next = ST_BAD_RANGE;
                    state_next      = S_DONE;
                end
                else if (i_reg == '0)
                begin
                    state_next = S_FIX_READ;
                end
                else
                begin
                    i_next     = i_reg - 1'b1;
                    mem_addr   = addr_of(bkt_reg, i_reg - 1'b1);
                    state_next = S_SC_CHECK;
                end
            end
            S_SC_CHECK:
            begin
                fix_next = mem_rdata;
                idx_next = i_reg;
                state_next = S_FIX_READ;
                if (e_reg < mem_rdata.start)
                begin
                    state_next = S_SC_READ;
                end
                else if (s_reg > mem_rdata.stop)
                begin
                    kind_next = KIND_INSERT;
                    idx_next  = i_reg + 1'b1;
                end
                else if (s_reg == mem_rdata.start && e_reg == mem_rdata.stop)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.value = v_reg;
                    res_status_next = ST_REPLACED;
                    state_next      = S_DONE;
                end
                else if (s_reg > mem_rdata.start && e_reg < mem_rdata.stop)
                begin
                    kind_next = KIND_SPLIT;
                end
                else if (s_reg == mem_rdata.start && e_reg < mem_rdata.stop)
                begin
                    kind_next = KIND_TRIM_START;
                end
                else if (s_reg > mem_rdata.start && e_reg == mem_rdata.stop)
                begin
                    kind_next = KIND_TRIM_END;
                end
                else
                begin
                    res_status_next = ST_OVERLAP;
                    state_next      = S_DONE;
                end
            end
            S_FIX_READ:
            begin
                if (need_fill > (FW+1)'(ENTRIES))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    fill_we    = 1'b1;
                    i_next     = fill;
                    state_next = S_SH_READ;
                end
            end
            S_SH_READ:
            begin
                if (i_reg == idx_reg
                    + ((kind_reg == KIND_INSERT || kind_reg == KIND_TRIM_START)
                       ? FW'(0) : FW'(1)))
                begin
                    state_next = S_FIX_WRITE;
                end
                else
                begin
                    i_next     = i_reg - 1'b1;
                    mem_addr   = addr_of(bkt_reg, i_reg - 1'b1);
                    state_next = S_SH_WRITE;
                end
            end
            S_SH_WRITE:
            begin
                mem_we     = 1'b1;
                mem_addr   = addr_of(bkt_reg, i_reg + FW'(gap));
                state_next = S_SH_READ;
            end
            S_FIX_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = S_PUT;
                case (kind_reg)
                    KIND_INSERT:
                    begin
                        mem_addr   = addr_of(bkt_reg, idx_reg);
                        mem_wdata  = '{start: s_reg, stop: e_reg, value: v_reg};
                        state_next = S_FIX_WAIT;
                    end
                    KIND_SPLIT:
                    begin
                        mem_addr  = addr_of(bkt_reg, idx_reg + FW'(2));
                        mem_wdata = '{start: e_reg + 1'b1, stop: fix_reg.stop,
                                      value: fix_reg.value};
                    end
                    KIND_TRIM_START:
                    begin
                        mem_addr  = addr_of(bkt_reg, idx_reg + FW'(1));
                        mem_wdata = '{start: e_reg + 1'b1, stop: fix_reg.stop,
                                      value: fix_reg.value};
                    end
                    default:
                    begin
                        mem_addr  = addr_of(bkt_reg, idx_reg);
                        mem_wdata = '{start: fix_reg.start, stop: s_reg - 1'b1,
                                      value: fix_reg.value};
                    end
                endcase
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '{start: s_reg, stop: e_reg, value: v_reg};
                mem_addr   = addr_of(bkt_reg, idx_reg
                    + ((kind_reg == KIND_TRIM_START) ? FW'(0) : FW'(1)));
                state_next = S_FIX_WAIT;
                if (kind_reg == KIND_SPLIT)
                begin
                    kind_next = KIND_TRIM_END;
                    state_next = S_FIX_WRITE;
                end
            end
            S_FIX_WAIT:
            begin
                res_status_next = ST_ADDED;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid  = res_valid_reg;
    assign res_value  = res_value_reg;
    assign res_status = res_status_reg;
endmodule
`default_nettype wire

// ----- src/bucketed_range_map_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bucketed_range_map_unit
// Range map over buckets of sorted disjoint ranges held in one entry memory.
// ============================================================================
// A lookup scans the bucket's entries upward from the first one and ends on a hit
// or, past the last filled entry, on a miss that returns the fallback value.
// An add scans down from the top of the bucket and then shifts the entries above
// the insert point up, one entry at a time, to make room.
// One transaction is in work at a time; the result register frees the input.
// Reset clears fill counts and control state; entry memory is not cleared.
module bucketed_range_map_unit #(
    parameter int BUCKETS = brm_pkg::BUCKETS_DEF,
    parameter int ENTRIES = brm_pkg::ENTRIES_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    brm_if.sink      in_ch,
    brm_if.source    out_ch,
    brm_if.sink      cfg_ch
);
    import brm_pkg::*;

    localparam int AW = $clog2(BUCKETS * ENTRIES);

    value_t        fallback_value_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    entry_t        mem_wdata, mem_rdata;
    logic [$bits(entry_t)-1:0] rdata_raw;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_value_reg <= '0;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            fallback_value_reg <= cfg_ch.data;
        end
    end

    brm_ctrl #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .in_cmd         (in_ch.data.cmd),
        .in_bucket      (in_ch.data.bucket),
        .in_key         (in_ch.data.key_low),
        .in_end         (in_ch.data.range_end),
        .in_value       (in_ch.data.value_id),
        .fallback_value (fallback_value_reg),
        .res_valid      (out_ch.valid),
        .res_ready      (out_ch.ready),
        .res_value      (out_ch.data.result_value),
        .res_status     (out_ch.data.status),
        .mem_we         (mem_we),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata)
    );

    brm_ram #(.WIDTH($bits(entry_t)), .DEPTH(BUCKETS * ENTRIES)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rdata_raw)
    );

    assign mem_rdata = entry_t'(rdata_raw);
endmodule
`default_nettype wire

// ----- src/brm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// brm_checker
// Port-level checks of the bucketed range map, bound to the top level.
// ============================================================================
module brm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_value,
    input wire logic [2:0]  out_status
);
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status))
        else $error("Result changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status <= 3'd6)
        else $error("Status code out of range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Second transaction taken while one is in work.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status >= 3'd2 |-> out_value == 16'd0)
        else $error("Add result carries a value.");
endmodule

bind bucketed_range_map_unit brm_checker u_brm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.data.result_value),
    .out_status (out_ch.data.status)
);
`default_nettype wire
